// ===== design/obq_pkg.sv =====
`timescale 1ns / 1ps
package obq_pkg;
    localparam int SampleW = 24;
    localparam int StateW  = 32;
    localparam int CoefW   = 32;
    localparam int GainW   = 16;
    localparam int CfgIdxW = 3;

    localparam logic signed [CoefW-1:0] PRE_B0 = 32'sd33374600;
    localparam logic signed [CoefW-1:0] PRE_A1 = 32'sd465351653;
    localparam logic signed [CoefW-1:0] PRE_A2 = 32'sd66749200 - 32'sd268435456;
    localparam logic signed [CoefW-1:0] PRE_B2 = -32'sd33374600;
    localparam logic signed [16:0] DRY_MIX = 17'sd16384;
    localparam logic signed [16:0] WET_MIX = 17'sd16384;

    localparam logic signed [StateW-1:0] GUARD_LIMIT = 32'sd2013265920;
    localparam logic [27:0] TANH_K  = 28'd226492416;

    localparam logic [CfgIdxW-1:0] REG_SLOPE = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_GAIN  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_B0    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_B1    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_B2    = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_A1    = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_A2    = 3'd6;

    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;

    function automatic logic signed [StateW-1:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) return 32'sh7fffffff;
        if (v < -50'sd2147483648) return 32'sh80000000;
        return v[StateW-1:0];
    endfunction
endpackage

// ===== design/obq_stream_if.sv =====
`timescale 1ns / 1ps
interface obq_stream_if #(parameter int W = 24);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/oversampled_biquad_synth_filter_unit.sv =====
`timescale 1ns / 1ps
// Oversampled biquad synth filter.
// Channels: i_in (sink) carries sample_in, o_out (source) carries sample_out,
// both signed Q1.23 with valid/ready; a transfer happens when both are high.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write one register per cycle
// (0 slope, 1 gain, 2..6 b0 b1 b2 a1 a2); write only while idle.
// One item at a time: a shared 32x32 multiply-accumulate unit runs the
// bandpass, mix and up to four main biquad passes, five taps per pass,
// one product per cycle; it also forms the gain product, the square and
// the numerator for tanh, which then uses a 54-step restoring divider.
// i_in ready stays low from the transfer until the result is taken, so a
// new sample is accepted only after the previous result has been taken.
// Reset clears all history and loads register defaults.
// When the receiver stalls, the result is held in the output register and
// no new sample is taken.
// If the final section output exceeds 15.0 all history is cleared and 0 is
// returned.
module oversampled_biquad_synth_filter_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    obq_stream_if.sink                   i_in,
    obq_stream_if.source                 o_out,
    input  logic                         i_cfg_we,
    input  logic [obq_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [obq_pkg::CoefW-1:0]    i_cfg_data
);
    import obq_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0, S_LOAD = 4'd1, S_MAC = 4'd2,
        S_BQ_END = 4'd3, S_MIX = 4'd4, S_MIX2 = 4'd5, S_GAIN = 4'd6,
        S_SQ = 4'd7, S_DIVS = 4'd8, S_DIVW = 4'd9, S_OUT = 4'd10,
        S_NUM = 4'd11;
    // pass codes
    localparam logic [2:0] P_PRE = 3'd0, P_F1 = 3'd1, P_F2 = 3'd2,
        P_S1 = 3'd3, P_S2 = 3'd4;

    logic              r_slope;
    logic [GainW-1:0]  r_gain;
    logic signed [CoefW-1:0] r_coef [5];
    logic signed [StateW-1:0] r_hp [4], r_hf [4], r_hs [4];
    logic signed [StateW-1:0] r_pmix, r_pfo;
    logic [3:0]  r_st;
    logic [2:0]  r_pass, r_tap;
    logic signed [StateW-1:0] r_x, r_mix, r_f, r_y;
    logic signed [49:0] r_acc;
    logic signed [63:0] r_prod;
    logic        r_pv;
    logic        r_neg;
    logic [24:0] r_m;
    logic [28:0] r_ks;
    logic [53:0] r_num;
    logic [31:0] r_den;
    logic [SampleW-1:0] r_out;
    logic        r_ov;

    // one shared multiplier
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_prod;
    assign w_prod = w_ma * w_mb;

    logic signed [StateW-1:0] w_h [4];
    logic signed [CoefW-1:0]  w_c;
    always_comb begin
        unique case (r_pass)
            P_PRE: w_h = r_hp;
            P_F1, P_F2: w_h = r_hf;
            default: w_h = r_hs;
        endcase
        if (r_pass == P_PRE) begin
            case (r_tap)
                3'd0: w_c = PRE_B0;
                3'd2: w_c = PRE_B2;
                3'd3: w_c = PRE_A1;
                3'd4: w_c = PRE_A2;
                default: w_c = '0;
            endcase
        end else begin
            w_c = (r_tap < 3'd5) ? r_coef[r_tap] : '0;
        end
    end

    logic signed [StateW-1:0] w_tv;
    always_comb begin
        case (r_tap)
            3'd0: w_tv = r_x;
            3'd1: w_tv = w_h[0];
            3'd2: w_tv = w_h[1];
            3'd3: w_tv = w_h[2];
            default: w_tv = w_h[3];
        endcase
        w_ma = w_c;
        w_mb = w_tv;
        if (r_st == S_MIX) begin
            w_ma = {{15{DRY_MIX[16]}}, DRY_MIX};
            w_mb = r_x;
        end else if (r_st == S_MIX2) begin
            w_ma = {{15{WET_MIX[16]}}, WET_MIX};
            w_mb = r_y;
        end else if (r_st == S_GAIN) begin
            w_ma = r_y;
            w_mb = {16'd0, r_gain};
        end else if (r_st == S_SQ) begin
            w_ma = {7'd0, r_m};
            w_mb = {7'd0, r_m};
        end else if (r_st == S_NUM) begin
            w_ma = {7'd0, r_m};
            w_mb = {3'd0, r_ks};
        end
    end

    logic signed [49:0] w_sum;
    logic signed [StateW-1:0] w_yq;
    assign w_sum = r_acc + (r_pv ? 50'(r_prod >>> 16) : 50'sd0);
    assign w_yq  = sat32((w_sum + 50'sd2048) >>> 12);

    logic signed [StateW-1:0] w_mid;
    always_comb begin
        logic signed [32:0] s;
        s = 33'(r_pass == P_F1 ? r_pmix : r_pfo) + 33'(r_pass == P_F1 ? r_mix : r_f);
        w_mid = s[32:1];
    end

    t_div_ctl    w_dctl;
    logic [53:0] w_quo;
    logic        w_ddone;
    assign w_dctl.start = (r_st == S_DIVS);
    assign w_dctl.busy  = (r_st == S_DIVW);
    obq_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_dctl),
        .i_num(r_num), .i_den(r_den), .o_quo(w_quo), .o_done(w_ddone));

    assign i_in.ready  = (r_st == S_IDLE);
    assign o_out.valid = (r_st == S_OUT);
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        logic signed [63:0] a;
        logic [49:0] sq;
        logic [26:0] sqs;
        logic [23:0] q;
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_slope <= 1'b0;
            r_gain <= 16'd4096;
            r_coef[0] <= 32'sd268435456;
            for (int i = 1; i < 5; i++) r_coef[i] <= '0;
            for (int i = 0; i < 4; i++) begin
                r_hp[i] <= '0; r_hf[i] <= '0; r_hs[i] <= '0;
            end
            r_pmix <= '0;
            r_pfo <= '0;
            r_pv <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SLOPE: r_slope <= i_cfg_data[0];
                    REG_GAIN:  r_gain <= i_cfg_data[GainW-1:0];
                    REG_B0, REG_B1, REG_B2, REG_A1, REG_A2:
                        r_coef[i_cfg_idx - REG_B0] <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_st)
                S_IDLE: if (i_in.valid) begin
                    r_x <= {{4{i_in.data[SampleW-1]}}, i_in.data, 4'd0};
                    r_pass <= P_PRE;
                    r_st <= S_LOAD;
                end
                S_LOAD: begin
                    r_tap <= '0;
                    r_acc <= '0;
                    r_pv <= 1'b0;
                    r_st <= S_MAC;
                    if (r_pass == P_F1 || r_pass == P_S1) r_x <= w_mid;
                    else if (r_pass == P_F2) r_x <= r_mix;
                    else if (r_pass == P_S2) r_x <= r_f;
                end
                S_MAC: begin
                    r_acc <= w_sum;
                    r_prod <= w_prod;
                    r_pv <= 1'b1;
                    r_tap <= r_tap + 3'd1;
                    if (r_tap == 3'd4) r_st <= S_BQ_END;
                end
                S_BQ_END: begin
                    r_pv <= 1'b0;
                    r_y <= w_yq;
                    unique case (r_pass)
                        P_PRE: begin
                            r_hp[1] <= r_hp[0]; r_hp[0] <= r_x;
                            r_hp[3] <= r_hp[2]; r_hp[2] <= w_yq;
                        end
                        P_F1, P_F2: begin
                            r_hf[1] <= r_hf[0]; r_hf[0] <= r_x;
                            r_hf[3] <= r_hf[2]; r_hf[2] <= w_yq;
                        end
                        default: begin
                            r_hs[1] <= r_hs[0]; r_hs[0] <= r_x;
                            r_hs[3] <= r_hs[2]; r_hs[2] <= w_yq;
                        end
                    endcase
                    unique case (r_pass)
                        P_PRE: r_st <= S_MIX;
                        P_F1: begin r_pass <= P_F2; r_st <= S_LOAD; end
                        P_F2: begin
                            r_pmix <= r_mix;
                            r_f <= w_yq;
                            if (r_slope) begin
                                r_pass <= P_S1; r_st <= S_LOAD;
                            end else r_st <= S_GAIN;
                        end
                        P_S1: begin r_pass <= P_S2; r_st <= S_LOAD; end
                        default: begin
                            r_pfo <= r_f;
                            r_st <= S_GAIN;
                        end
                    endcase
                end
                S_MIX: begin
                    r_prod <= w_prod;
                    r_st <= S_MIX2;
                end
                S_MIX2: begin
                    a = r_prod + w_prod + 64'sd16384;
                    r_mix <= sat32(50'(a >>> 15));
                    r_pass <= P_F1;
                    r_st <= S_LOAD;
                end
                S_GAIN: begin
                    r_ov <= (r_y > GUARD_LIMIT);
                    a = (w_prod + 64'sd32768) >>> 16;
                    r_neg <= a[63];
                    if (a >= 64'sd25165824 || a <= -64'sd25165824) begin
                        r_out <= a[63] ? 24'h800000 : 24'h7fffff;
                        r_st <= S_OUT;
                        if (r_y > GUARD_LIMIT) r_out <= '0;
                    end else begin
                        r_m <= a[63] ? 25'(-a) : a[24:0];
                        r_st <= S_SQ;
                    end
                    if (r_y > GUARD_LIMIT) begin
                        r_st <= S_OUT;
                        r_out <= '0;
                        for (int i = 0; i < 4; i++) begin
                            r_hp[i] <= '0; r_hf[i] <= '0; r_hs[i] <= '0;
                        end
                        r_pmix <= '0;
                        r_pfo <= '0;
                    end
                end
                S_SQ: begin
                    sq = w_prod[49:0];
                    sqs = sq[49:23];
                    r_ks <= {1'b0, TANH_K} + {2'b0, sqs};
                    r_den <= {4'd0, TANH_K} + 32'd9 * {5'd0, sqs};
                    r_st <= S_NUM;
                end
                // numerator m * (K + s) through the shared multiplier
                S_NUM: begin
                    r_num <= w_prod[53:0];
                    r_st <= S_DIVS;
                end
                S_DIVS: r_st <= S_DIVW;
                S_DIVW: if (w_ddone) begin
                    if (w_quo > 54'd8388607) q = r_neg ? 24'h800000 : 24'h7fffff;
                    else q = r_neg ? -w_quo[23:0] : w_quo[23:0];
                    r_out <= q;
                    r_st <= S_OUT;
                end
                S_OUT: if (o_out.ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_rdy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(r_out))
        else $error("result dropped");
    a_tap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_MAC |-> r_tap < 3'd5) else $error("tap overrun");
    a_ov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_OUT && $past(r_st) == S_GAIN && r_ov |-> r_out == '0)
        else $error("guard output");
`endif
endmodule

// ===== design/obq_div.sv =====
`timescale 1ns / 1ps
module obq_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  obq_pkg::t_div_ctl   i_ctl,
    input  logic [53:0]         i_num,
    input  logic [31:0]         i_den,
    output logic [53:0]         o_quo,
    output logic                o_done
);
    import obq_pkg::*;
    logic [53:0] r_quo;
    logic [32:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_run;
    logic [33:0] w_try;
    assign w_try = {r_rem, r_quo[53]} - {2'b0, i_den};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_ctl.start) begin
            r_run <= 1'b1;
            r_cnt <= 6'd54;
        end else if (r_run) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_run <= 1'b0;
        end
        if (i_ctl.start) begin
            r_quo <= i_num;
            r_rem <= '0;
        end else if (r_run) begin
            if (!w_try[33]) begin
                r_rem <= w_try[32:0];
                r_quo <= {r_quo[52:0], 1'b1};
            end else begin
                r_rem <= {r_rem[31:0], r_quo[53]};
                r_quo <= {r_quo[52:0], 1'b0};
            end
        end
    end
    assign o_quo  = r_quo;
    assign o_done = !r_run && !i_ctl.start;
endmodule

// ===== dv/obq_checker.sv =====
`timescale 1ns / 1ps
module obq_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [obq_pkg::SampleW-1:0] i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [obq_pkg::SampleW-1:0] i_out_data,
    input  logic                        i_cfg_we,
    input  logic [obq_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [obq_pkg::CoefW-1:0]   i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_out_count
);
    import obq_pkg::*;

    localparam longint GuardQ27 = 64'sd15 * 64'sd134217728;
    localparam longint TanhK    = 64'sd27 * 64'sd8388608;

    logic           slope_24db;
    longint         gain;
    longint         taps [5];
    longint         bp_taps [5];
    int             pre_h [4];
    int             first_h [4];
    int             second_h [4];
    int             last_mix;
    int             last_first;
    logic [SampleW-1:0] expected_samples [$];

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    // One biquad pass over history h (x1, x2, y1, y2).
    function automatic int run_section(ref int h [4], input int x, input longint c [5]);
        longint acc;
        int y;
        acc = ((c[0] * longint'(x)) >>> 16) + ((c[1] * longint'(h[0])) >>> 16)
            + ((c[2] * longint'(h[1])) >>> 16) + ((c[3] * longint'(h[2])) >>> 16)
            + ((c[4] * longint'(h[3])) >>> 16);
        y = clamp32((acc + 2048) >>> 12);
        h[1] = h[0];
        h[0] = x;
        h[3] = h[2];
        h[2] = y;
        return y;
    endfunction

    function automatic int mid(int a, int b);
        return int'((longint'(a) + longint'(b)) >>> 1);
    endfunction

    function automatic longint soft_clip(int fin);
        longint arg, m, s, r;
        arg = (longint'(fin) * gain + 32768) >>> 16;
        m = (arg < 0) ? -arg : arg;
        if (m >= 3 * 8388608) return (arg < 0) ? -8388608 : 8388607;
        s = (m * m) >>> 23;
        r = (m * (TanhK + s)) / (TanhK + 9 * s);
        if (arg < 0) return (r > 8388608) ? -8388608 : -r;
        return (r > 8388607) ? 8388607 : r;
    endfunction

    function automatic void clear_history();
        for (int i = 0; i < 4; i++) begin
            pre_h[i] = 0;
            first_h[i] = 0;
            second_h[i] = 0;
        end
        last_mix = 0;
        last_first = 0;
    endfunction

    function automatic logic [SampleW-1:0] filter_sample(logic [SampleW-1:0] raw);
        int x, bp, mx, f, fin, dummy;
        longint res;
        x = int'(longint'($signed(raw)) * 16);
        bp = run_section(pre_h, x, bp_taps);
        mx = clamp32((longint'(DRY_MIX) * x + longint'(WET_MIX) * bp + 16384) >>> 15);
        dummy = run_section(first_h, mid(last_mix, mx), taps);
        f = run_section(first_h, mx, taps);
        last_mix = mx;
        fin = f;
        if (slope_24db) begin
            dummy = run_section(second_h, mid(last_first, f), taps);
            fin = run_section(second_h, f, taps);
            last_first = f;
        end
        if (longint'(fin) > GuardQ27) begin
            clear_history();
            res = 0;
        end else begin
            res = soft_clip(fin);
        end
        return res[SampleW-1:0];
    endfunction

    assign o_pending = expected_samples.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slope_24db <= 1'b0;
            gain = 4096;
            taps = '{64'sd268435456, 0, 0, 0, 0};
            bp_taps = '{longint'(PRE_B0), 0, longint'(PRE_B2), longint'(PRE_A1),
                        2 * longint'(PRE_B0) - 64'sd268435456};
            clear_history();
            expected_samples.delete();
            o_fail_count <= 0;
            o_out_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SLOPE: slope_24db <= i_cfg_data[0];
                    REG_GAIN:  gain = longint'(i_cfg_data[GainW-1:0]);
                    REG_B0, REG_B1, REG_B2, REG_A1, REG_A2:
                        taps[i_cfg_idx - REG_B0] = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_samples.push_back(filter_sample(i_in_data));
            if (i_out_valid && i_out_ready) begin
                o_out_count <= o_out_count + 1;
                if (expected_samples.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected sample_out %0d", $signed(i_out_data));
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    if (i_out_data !== expected_samples[0]) begin
                        if (o_fail_count < 10)
                            $display("sample_out mismatch: expected %0d actual %0d",
                                     $signed(expected_samples[0]), $signed(i_out_data));
                        o_fail_count <= o_fail_count + 1;
                    end
                    void'(expected_samples.pop_front());
                end
            end
        end
    end
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import obq_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_idx = '0;
    logic [CoefW-1:0] i_cfg_data = '0;
    int fail_count, pending, out_count;
    logic sink_enable = 1'b1;
    logic idle_on = 1'b1;
    int   long_hold = 0;
    logic [SampleW-1:0] corner_samples [8] = '{24'h000000, 24'h7fffff, 24'h800000,
        24'h000001, 24'hffffff, 24'h555555, 24'haaaaaa, 24'h400000};

    obq_stream_if #(SampleW) in_ch ();
    obq_stream_if #(SampleW) out_ch ();

    always #10 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    oversampled_biquad_synth_filter_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    obq_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready), .i_in_data(in_ch.data),
        .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready), .i_out_data(out_ch.data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_out_count(out_count)
    );

    // Receiver: random stall bursts, plus one long hold-off on request.
    always begin
        int n;
        @(posedge i_clk);
        if (long_hold > 0) begin
            out_ch.ready <= 1'b0;
            repeat (long_hold) @(posedge i_clk);
            long_hold = 0;
        end else if (sink_enable && idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 14);
            out_ch.ready <= 1'b0;
            repeat (n - 1) @(posedge i_clk);
        end else begin
            out_ch.ready <= sink_enable;
        end
    end

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CoefW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_sample(logic [SampleW-1:0] s);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= s;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic go_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic load_taps(int b0, int b1, int b2, int a1, int a2);
        write_reg(REG_B0, b0);
        write_reg(REG_B1, b1);
        write_reg(REG_B2, b2);
        write_reg(REG_A1, a1);
        write_reg(REG_A2, a2);
    endtask

    // Random stable-ish sample, mostly small, sometimes full scale.
    function automatic logic [SampleW-1:0] pick_sample();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
            default: return SampleW'($signed($urandom_range(0, 400000)) - 200000);
        endcase
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: default taps, field extremes.
        foreach (corner_samples[i])
            send_sample(corner_samples[i]);
        go_idle();

        // Large gain drives tanh to its clip, 24 dB mode, then overflow guard.
        write_reg(REG_GAIN, 16'hffff);
        write_reg(REG_SLOPE, 1'b1);
        repeat (4) send_sample(24'h7fffff);
        repeat (2) send_sample(24'h800000);
        go_idle();
        load_taps(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        repeat (5) send_sample(24'h7fffff);
        go_idle();
        load_taps(32'h80000000, 0, 0, 32'h80000000, 32'h80000000);
        write_reg(REG_GAIN, 16'h0000);
        write_reg(3'd7, 32'hffffffff);
        repeat (4) send_sample(24'h800000);
        go_idle();

        // Pressure: hold the receiver off while the sender keeps offering.
        write_reg(REG_SLOPE, 1'b0);
        write_reg(REG_GAIN, 16'd4096);
        load_taps(32'sd268435456, 0, 0, 0, 0);
        long_hold = 600;
        repeat (6) send_sample(pick_sample());
        go_idle();

        // Random phases over several settings.
        for (int phase = 0; phase < 8; phase++) begin
            write_reg(REG_SLOPE, phase[0]);
            write_reg(REG_GAIN, (phase == 7) ? 16'hffff : $urandom_range(0, 16384));
            if (phase % 3 == 2)
                load_taps($urandom, $urandom, $urandom, $urandom, $urandom);
            else
                load_taps(32'sd40000000 + $urandom_range(0, 20000000),
                          $urandom_range(0, 80000000), $urandom_range(0, 40000000),
                          32'sd200000000 + $urandom_range(0, 100000000),
                          -32'sd100000000 - $urandom_range(0, 50000000));
            if (phase == 7) idle_on = 1'b0;
            repeat (78) send_sample(pick_sample());
            go_idle();
        end

        repeat (200) @(posedge i_clk);
        $display("Covered extremes, tanh clip, overflow guard, both slopes and");
        $display("random coefficient sets with stalls; %0d samples checked", out_count);
        if (fail_count == 0 && pending == 0)
            $display("[oversampled_biquad_synth_filter_unit] OK");
        else
            $display("[oversampled_biquad_synth_filter_unit] ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("[oversampled_biquad_synth_filter_unit] ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
design/obq_pkg.sv
design/obq_stream_if.sv
design/obq_div.sv
design/oversampled_biquad_synth_filter_unit.sv
dv/obq_checker.sv
dv/tb_top.sv
